FILE: hw/rtl/assert_macros.svh
// Assertion macros for the direction sample warp RTL.
// Each macro expects signals named clock and reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a full property on every rising clock edge outside of reset.
`define DSW_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("direction sample warp: assertion failed");

// Checks that a consequent holds in the same cycle as its antecedent.
`define DSW_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("direction sample warp: implication failed");

`endif

FILE: hw/rtl/dsw_pkg.sv
// Shared constants, word types and the arctangent table for the direction sample warp.
// No dependencies; every RTL module of the block imports this package.
package dsw_pkg;

   localparam int RAND_BITS    = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int FRAC         = 30;

   localparam int UP30 = (RAND_BITS <= 30) ? 30 - RAND_BITS : 0;
   localparam int DN30 = (RAND_BITS > 30) ? RAND_BITS - 30 : 0;
   localparam int UP32 = (RAND_BITS <= 32) ? 32 - RAND_BITS : 0;
   localparam int DN32 = (RAND_BITS > 32) ? RAND_BITS - 32 : 0;

   localparam int U_W      = FRAC;          // uniform value in Q0.30
   localparam int DW       = FRAC + 4;      // signed Q.30 datapath width
   localparam int ARG_W    = FRAC + 1;      // root argument, at most 1.0
   localparam int ROOT_W   = FRAC + 1;      // root result, at most 1.0
   localparam int SQ_W     = 2 * FRAC + 2;  // root remainder width
   localparam int PHASE_W  = 32;
   localparam int MODE_W   = 3;
   localparam int OUT_W    = 16;
   localparam int ATAN_LEN = 24;

   localparam logic [MODE_W-1:0] MODE_SPHERE = 3'd0;
   localparam logic [MODE_W-1:0] MODE_HEMI   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_COSINE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CONE   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_TRI    = 3'd4;

   localparam logic [FRAC-1:0] KGAIN = 30'd652032874;

   localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
   };

   // Fields that ride alongside the square root pipeline.
   typedef struct packed {
      logic [MODE_W-1:0]    mode;
      logic signed [DW-1:0] z;
      logic [PHASE_W-1:0]   phase;
      logic [U_W-1:0]       u2;
   } root_side_type;

   // Fields that ride alongside the rotation pipeline.
   typedef struct packed {
      logic [MODE_W-1:0]    mode;
      logic signed [DW-1:0] z;
      logic signed [DW-1:0] tri_x;
      logic signed [DW-1:0] tri_y;
      logic [1:0]           quad;
   } rot_side_type;

endpackage

FILE: hw/rtl/dsw_root_pair.sv
// Two lockstep integer square root pipelines, one result bit per stage.
// Depends on dsw_pkg for widths and the side word type.
module dsw_root_pair (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  logic [dsw_pkg::ARG_W-1:0]   arg_a,
   input  logic [dsw_pkg::ARG_W-1:0]   arg_b,
   input  dsw_pkg::root_side_type      side_in,
   output logic                        out_valid,
   output logic [dsw_pkg::ROOT_W-1:0]  root_a,
   output logic [dsw_pkg::ROOT_W-1:0]  root_b,
   output dsw_pkg::root_side_type      side_out
);
   import dsw_pkg::*;

   localparam int STEPS = ROOT_W;

   typedef struct packed {
      logic [SQ_W-1:0] rem;
      logic [SQ_W-1:0] res;
   } acc_type;

   function automatic acc_type root_step(input acc_type a, input logic [SQ_W-1:0] bitv);
      acc_type         o;
      logic [SQ_W-1:0] t;
      t = a.res + bitv;
      if (a.rem >= t) begin
         o.rem = a.rem - t;
         o.res = (a.res >> 1) + bitv;
      end else begin
         o.rem = a.rem;
         o.res = a.res >> 1;
      end
      return o;
   endfunction

   acc_type       acc_a_ff  [STEPS];
   acc_type       acc_b_ff  [STEPS];
   root_side_type side_ff   [STEPS];
   logic          valid_ff  [STEPS];

   genvar k;
   for (k = 0; k < STEPS; k++) begin : g_step
      localparam int              SH   = 2 * (STEPS - 1 - k);
      localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << SH;
      acc_type       prev_a;
      acc_type       prev_b;
      root_side_type prev_side;
      logic          prev_valid;

      if (k == 0) begin : g_first
         assign prev_a.rem = SQ_W'(arg_a) << FRAC;
         assign prev_a.res = '0;
         assign prev_b.rem = SQ_W'(arg_b) << FRAC;
         assign prev_b.res = '0;
         assign prev_side  = side_in;
         assign prev_valid = in_valid;
      end else begin : g_next
         assign prev_a     = acc_a_ff[k-1];
         assign prev_b     = acc_b_ff[k-1];
         assign prev_side  = side_ff[k-1];
         assign prev_valid = valid_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            acc_a_ff[k] <= root_step(prev_a, BITV);
            acc_b_ff[k] <= root_step(prev_b, BITV);
            side_ff[k]  <= prev_side;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= prev_valid;
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign root_a    = acc_a_ff[STEPS-1].res[ROOT_W-1:0];
   assign root_b    = acc_b_ff[STEPS-1].res[ROOT_W-1:0];
   assign side_out  = side_ff[STEPS-1];

endmodule

FILE: hw/rtl/dsw_rotator.sv
// Pipelined rotation CORDIC, one micro-rotation per stage, first quadrant only.
// Depends on dsw_pkg for widths, step count, arctangent table and side word type.
module dsw_rotator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic signed [dsw_pkg::DW-1:0] x_in,
   input  logic signed [dsw_pkg::DW-1:0] ang_in,
   input  dsw_pkg::rot_side_type         side_in,
   output logic                          out_valid,
   output logic signed [dsw_pkg::DW-1:0] x_out,
   output logic signed [dsw_pkg::DW-1:0] y_out,
   output dsw_pkg::rot_side_type         side_out
);
   import dsw_pkg::*;

   logic signed [DW-1:0] x_ff     [CORDIC_STEPS];
   logic signed [DW-1:0] y_ff     [CORDIC_STEPS];
   logic signed [DW-1:0] z_ff     [CORDIC_STEPS];
   rot_side_type         side_ff  [CORDIC_STEPS];
   logic                 valid_ff [CORDIC_STEPS];

   genvar k;
   for (k = 0; k < CORDIC_STEPS; k++) begin : g_step
      localparam logic signed [DW-1:0] ATAN = $signed({{(DW-32){1'b0}}, ATAN_TURNS[k]});
      logic signed [DW-1:0] px;
      logic signed [DW-1:0] py;
      logic signed [DW-1:0] pz;
      rot_side_type         ps;
      logic                 pv;

      if (k == 0) begin : g_first
         assign px = x_in;
         assign py = '0;
         assign pz = ang_in;
         assign ps = side_in;
         assign pv = in_valid;
      end else begin : g_next
         assign px = x_ff[k-1];
         assign py = y_ff[k-1];
         assign pz = z_ff[k-1];
         assign ps = side_ff[k-1];
         assign pv = valid_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            if (pz >= 0) begin
               x_ff[k] <= px - (py >>> k);
               y_ff[k] <= py + (px >>> k);
               z_ff[k] <= pz - ATAN;
            end else begin
               x_ff[k] <= px + (py >>> k);
               y_ff[k] <= py - (px >>> k);
               z_ff[k] <= pz + ATAN;
            end
            side_ff[k] <= ps;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= pv;
         end
      end
   end

   assign out_valid = valid_ff[CORDIC_STEPS-1];
   assign x_out     = x_ff[CORDIC_STEPS-1];
   assign y_out     = y_ff[CORDIC_STEPS-1];
   assign side_out  = side_ff[CORDIC_STEPS-1];

endmodule

FILE: hw/rtl/direction_sample_warp_top.sv
// Top level of the direction sample warp: maps two uniform numbers to a direction.
// Depends on dsw_pkg, dsw_root_pair, dsw_rotator and assert_macros.svh.
//
// Usage: the request channel carries one word per item: a mode (sphere,
// hemisphere, cosine hemisphere, cone, triangle barycentric), two uniform
// numbers in unsigned Q0.16 and a cone cosine in signed Q2.14. The response
// channel returns one word per request with the direction x, y, z in signed
// Q2.14, saturated to plus or minus one. Both channels use valid and stall.
// The block is one pipeline of 54 register stages: four stages form the
// square root arguments, 31 stages resolve one root bit each, two stages
// scale the root, 16 stages run the CORDIC micro-rotations and the last
// stage folds the quadrant, rounds and saturates. A new request can be
// accepted on every cycle unless a held result word stalls the pipeline,
// so throughput is one word per clock when the receiver does not stall.
// When the receiver stalls while a result word is waiting, the whole pipeline
// freezes and the request side is stalled in the same cycle; nothing is lost
// or repeated. A synchronous reset clears every valid bit; the block is then
// ready at once and holds no other state.
`include "assert_macros.svh"

module direction_sample_warp_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [dsw_pkg::MODE_W-1:0]         req_type,
   input  logic [15:0]                        req_rand_a,
   input  logic [15:0]                        req_rand_b,
   input  logic signed [15:0]                 req_cone_cos_max,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [dsw_pkg::OUT_W-1:0]   rsp_dir_x,
   output logic signed [dsw_pkg::OUT_W-1:0]   rsp_dir_y,
   output logic signed [dsw_pkg::OUT_W-1:0]   rsp_dir_z
);
   import dsw_pkg::*;

   localparam logic [63:0]          RAND_MASK = (64'd1 << RAND_BITS) - 64'd1;
   localparam logic signed [DW-1:0] ONE_Q    = DW'(64'd1 << FRAC);
   localparam logic [ARG_W-1:0]     ONE_ARG  = ARG_W'(64'd1 << FRAC);
   localparam int                   PC_W     = U_W + 16;
   localparam int                   SQZ_W    = 2 * (FRAC + 1);
   localparam int                   PK_W     = ROOT_W + U_W;
   localparam logic [DW-1:0]        ROUND16  = DW'(64'd1 << 15);
   localparam logic [OUT_W-1:0]     SAT_MAG  = OUT_W'(16384);

   // Q.30 to Q2.14: round the magnitude half away from zero, then saturate.
   function automatic logic signed [OUT_W-1:0] to_q14(input logic signed [DW-1:0] v);
      logic [DW-1:0]    mag;
      logic [DW-1:0]    m;
      logic [OUT_W-1:0] sat;
      mag = v[DW-1] ? DW'(-v) : DW'(v);
      m   = (mag + ROUND16) >> 16;
      sat = (m > DW'(SAT_MAG)) ? SAT_MAG : m[OUT_W-1:0];
      return v[DW-1] ? -$signed(sat) : $signed(sat);
   endfunction

   // The pipeline moves unless a finished word is held by the receiver.
   logic rsp_valid_ff;
   logic adv;
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = rsp_valid_ff && rsp_stall;

   // Stage 1: scale the uniforms to Q0.30 and start the cone product.
   logic [63:0]        ra64, rb64;
   logic [U_W-1:0]     u1_in, u2_in;
   logic [PHASE_W-1:0] phase_in;
   logic [15:0]        craw, cmag;

   assign ra64     = {48'd0, req_rand_a} & RAND_MASK;
   assign rb64     = {48'd0, req_rand_b} & RAND_MASK;
   assign u1_in    = U_W'((ra64 << UP30) >> DN30);
   assign u2_in    = U_W'((rb64 << UP30) >> DN30);
   assign phase_in = PHASE_W'((rb64 << UP32) >> DN32);
   assign craw     = req_cone_cos_max;
   assign cmag     = craw[15] ? (~craw + 16'd1) : craw;

   logic               s1_valid_ff;
   logic [MODE_W-1:0]  s1_mode_ff;
   logic [U_W-1:0]     s1_u1_ff, s1_u2_ff;
   logic [PHASE_W-1:0] s1_phase_ff;
   logic [PC_W-1:0]    s1_pc_ff;
   logic               s1_neg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
      end
   end

   // The cone cosine is Q2.14 and sits 16 bits up in Q.30, so the product is
   // u1 times the raw magnitude with the rounding point 14 bits up.
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_mode_ff  <= req_type;
         s1_u1_ff    <= u1_in;
         s1_u2_ff    <= u2_in;
         s1_phase_ff <= phase_in;
         s1_pc_ff    <= PC_W'(u1_in) * PC_W'(cmag);
         s1_neg_ff   <= craw[15];
      end
   end

   // Stage 2: the cosine of the polar angle for the sphere, hemisphere and cone.
   logic [DW-1:0]        mc_mag;
   logic signed [DW-1:0] mc, u1z, z_in;

   assign mc_mag = DW'((s1_pc_ff + PC_W'(1 << 13)) >> 14);
   assign mc     = s1_neg_ff ? -$signed(mc_mag) : $signed(mc_mag);
   assign u1z    = DW'(s1_u1_ff);

   always_comb begin
      unique case (s1_mode_ff)
         MODE_SPHERE: z_in = ONE_Q - (u1z <<< 1);
         MODE_HEMI:   z_in = u1z;
         MODE_CONE:   z_in = ONE_Q - u1z + mc;
         default:     z_in = '0;
      endcase
   end

   logic                 s2_valid_ff;
   logic [MODE_W-1:0]    s2_mode_ff;
   logic [U_W-1:0]       s2_u1_ff, s2_u2_ff;
   logic [PHASE_W-1:0]   s2_phase_ff;
   logic signed [DW-1:0] s2_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_mode_ff  <= s1_mode_ff;
         s2_u1_ff    <= s1_u1_ff;
         s2_u2_ff    <= s1_u2_ff;
         s2_phase_ff <= s1_phase_ff;
         s2_z_ff     <= z_in;
      end
   end

   // Stage 3: square z. Beyond unit magnitude 1 - z^2 is negative and the
   // sine clamps to zero, so only the low FRAC+1 bits need to be multiplied.
   logic [DW-1:0]   zmag;
   logic [FRAC:0]   zlow;

   assign zmag = s2_z_ff[DW-1] ? DW'(-s2_z_ff) : DW'(s2_z_ff);
   assign zlow = zmag[FRAC:0];

   logic                 s3_valid_ff;
   logic [MODE_W-1:0]    s3_mode_ff;
   logic [U_W-1:0]       s3_u1_ff, s3_u2_ff;
   logic [PHASE_W-1:0]   s3_phase_ff;
   logic signed [DW-1:0] s3_z_ff;
   logic [SQZ_W-1:0]     s3_zsq_ff;
   logic                 s3_big_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_mode_ff  <= s2_mode_ff;
         s3_u1_ff    <= s2_u1_ff;
         s3_u2_ff    <= s2_u2_ff;
         s3_phase_ff <= s2_phase_ff;
         s3_z_ff     <= s2_z_ff;
         s3_zsq_ff   <= SQZ_W'(zlow) * SQZ_W'(zlow);
         s3_big_ff   <= zmag > DW'(ONE_Q);
      end
   end

   // Stage 4: square root arguments. Root A is the sine or sqrt(u1);
   // root B is only used by the cosine hemisphere for its z.
   logic [ARG_W-1:0] zsq_q, arg_a_in, arg_b_in;

   assign zsq_q = ARG_W'((s3_zsq_ff + SQZ_W'(1 << 29)) >> FRAC);

   always_comb begin
      arg_b_in = '0;
      unique case (s3_mode_ff) inside
         MODE_SPHERE, MODE_HEMI, MODE_CONE: begin
            arg_a_in = s3_big_ff ? '0 : ONE_ARG - zsq_q;
         end
         MODE_COSINE: begin
            arg_a_in = ARG_W'(s3_u1_ff);
            arg_b_in = ONE_ARG - ARG_W'(s3_u1_ff);
         end
         MODE_TRI: arg_a_in = ARG_W'(s3_u1_ff);
         default:  arg_a_in = '0;
      endcase
   end

   logic             s4_valid_ff;
   logic [ARG_W-1:0] s4_arg_a_ff, s4_arg_b_ff;
   root_side_type    s4_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_arg_a_ff      <= arg_a_in;
         s4_arg_b_ff      <= arg_b_in;
         s4_side_ff.mode  <= s3_mode_ff;
         s4_side_ff.z     <= s3_z_ff;
         s4_side_ff.phase <= s3_phase_ff;
         s4_side_ff.u2    <= s3_u2_ff;
      end
   end

   // Square roots, one result bit per stage.
   logic              rt_valid;
   logic [ROOT_W-1:0] rt_a, rt_b;
   root_side_type     rt_side;

   dsw_root_pair u_roots (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (s4_valid_ff),
      .arg_a    (s4_arg_a_ff),
      .arg_b    (s4_arg_b_ff),
      .side_in  (s4_side_ff),
      .out_valid(rt_valid),
      .root_a   (rt_a),
      .root_b   (rt_b),
      .side_out (rt_side)
   );

   // Stage P: scale the root by the CORDIC gain and, for the triangle, by u2.
   logic              s5_valid_ff;
   logic [PK_W-1:0]   s5_pk_ff, s5_pt_ff;
   logic [ROOT_W-1:0] s5_root_a_ff, s5_root_b_ff;
   root_side_type     s5_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (adv) begin
         s5_valid_ff <= rt_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_pk_ff     <= PK_W'(rt_a) * PK_W'(KGAIN);
         s5_pt_ff     <= PK_W'(rt_a) * PK_W'(rt_side.u2);
         s5_root_a_ff <= rt_a;
         s5_root_b_ff <= rt_b;
         s5_side_ff   <= rt_side;
      end
   end

   // Stage R: round the products and set up the rotation. The top two phase
   // bits pick the quadrant; the rest is the angle within it.
   logic                 s6_valid_ff;
   logic signed [DW-1:0] s6_x0_ff, s6_ang_ff;
   rot_side_type         s6_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (adv) begin
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_x0_ff          <= DW'((s5_pk_ff + PK_W'(1 << 29)) >> FRAC);
         s6_ang_ff         <= DW'(s5_side_ff.phase[PHASE_W-3:0]);
         s6_side_ff.mode   <= s5_side_ff.mode;
         s6_side_ff.z      <= (s5_side_ff.mode == MODE_COSINE) ?
                              DW'(s5_root_b_ff) : s5_side_ff.z;
         s6_side_ff.tri_x  <= ONE_Q - DW'(s5_root_a_ff);
         s6_side_ff.tri_y  <= DW'((s5_pt_ff + PK_W'(1 << 29)) >> FRAC);
         s6_side_ff.quad   <= s5_side_ff.phase[PHASE_W-1:PHASE_W-2];
      end
   end

   // CORDIC rotation of (s*K, 0) by the in-quadrant angle.
   logic                 rot_valid;
   logic signed [DW-1:0] rot_x, rot_y;
   rot_side_type         rot_side;

   dsw_rotator u_rotator (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (s6_valid_ff),
      .x_in     (s6_x0_ff),
      .ang_in   (s6_ang_ff),
      .side_in  (s6_side_ff),
      .out_valid(rot_valid),
      .x_out    (rot_x),
      .y_out    (rot_y),
      .side_out (rot_side)
   );

   // Output stage: quadrant fold, mode selection, rounding and saturation.
   logic signed [DW-1:0] cx, sy, ox, oy, oz;

   always_comb begin
      case (rot_side.quad)
         2'd0: begin
            cx = rot_x;
            sy = rot_y;
         end
         2'd1: begin
            cx = -rot_y;
            sy = rot_x;
         end
         2'd2: begin
            cx = -rot_x;
            sy = -rot_y;
         end
         default: begin
            cx = rot_y;
            sy = -rot_x;
         end
      endcase
   end

   always_comb begin
      unique case (rot_side.mode) inside
         MODE_SPHERE, MODE_HEMI, MODE_COSINE, MODE_CONE: begin
            ox = cx;
            oy = sy;
            oz = rot_side.z;
         end
         MODE_TRI: begin
            ox = rot_side.tri_x;
            oy = rot_side.tri_y;
            oz = '0;
         end
         default: begin
            ox = '0;
            oy = '0;
            oz = '0;
         end
      endcase
   end

   logic signed [OUT_W-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= rot_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_x_ff <= to_q14(ox);
         rsp_y_ff <= to_q14(oy);
         rsp_z_ff <= to_q14(oz);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_dir_x = rsp_x_ff;
   assign rsp_dir_y = rsp_y_ff;
   assign rsp_dir_z = rsp_z_ff;

   // Every component of the response word lies within plus or minus one.
   logic out_in_range;
   assign out_in_range = (rsp_dir_x <= 16'sd16384) && (rsp_dir_x >= -16'sd16384) &&
                         (rsp_dir_y <= 16'sd16384) && (rsp_dir_y >= -16'sd16384) &&
                         (rsp_dir_z <= 16'sd16384) && (rsp_dir_z >= -16'sd16384);

   // An accepted request word always occupies the first stage next cycle.
   `DSW_ASSERT(a_accept_enters, (req_valid && !req_stall) |=> s1_valid_ff)
   // A held result word freezes the front of the pipeline.
   `DSW_ASSERT(a_stall_freezes, (rsp_valid && rsp_stall) |=> (s1_valid_ff == $past(s1_valid_ff)))
   // Saturation keeps every component within one.
   `DSW_ASSERT_IMPLY(a_out_range, rsp_valid, out_in_range)

endmodule

FILE: verif/direction_sample_warp_tb.sv
// Self-checking testbench for direction_sample_warp_top: predicts each direction word in
// SystemVerilog and checks every response word in order. Depends on dsw_pkg.
`timescale 1ns / 1ps

// Holds predicted direction words and compares returned words against them.
class direction_scoreboard;
   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } dir_word_type;

   dir_word_type pending_dirs[$];
   int unsigned error_count = 0;
   int unsigned checked_count = 0;

   static function longint unsigned mag(longint v);
      return v < 0 ? longint'(0) - v : v;
   endfunction

   static function longint mul_q30(longint a, longint b);
      logic neg;
      longint unsigned p;
      neg = (a < 0) != (b < 0);
      p = (mag(a) * mag(b) + (64'd1 << 29)) >> 30;
      return neg ? -longint'(p) : longint'(p);
   endfunction

   static function longint floor_sh(longint v, int sh);
      return v >>> sh;
   endfunction

   static function longint root_q30(longint v);
      longint unsigned n, res, bitv;
      if (v <= 0) return 0;
      n = longint'(v) << 30;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return longint'(res);
   endfunction

   static function logic signed [15:0] round_q14(longint v);
      longint unsigned m;
      m = (mag(v) + (64'd1 << 15)) >> 16;
      if (m > 16384) m = 16384;
      return v < 0 ? -16'(m) : 16'(m);
   endfunction

   // Rotates (s, 0) by a phase in turns; returns s*cos and s*sin in Q.30.
   static function void rotate(longint s, logic [31:0] phase, output longint cx,
                               output longint sy);
      longint x, y, z, nx;
      x = mul_q30(s, longint'(dsw_pkg::KGAIN));
      y = 0;
      z = longint'(phase[29:0]);
      for (int i = 0; i < dsw_pkg::CORDIC_STEPS; i++) begin
         if (z >= 0) begin
            nx = x - floor_sh(y, i);
            y = y + floor_sh(x, i);
            z = z - longint'(dsw_pkg::ATAN_TURNS[i]);
         end else begin
            nx = x + floor_sh(y, i);
            y = y - floor_sh(x, i);
            z = z + longint'(dsw_pkg::ATAN_TURNS[i]);
         end
         x = nx;
      end
      case (phase[31:30])
         2'd0: begin cx = x;  sy = y;  end
         2'd1: begin cx = -y; sy = x;  end
         2'd2: begin cx = -x; sy = -y; end
         default: begin cx = y; sy = -x; end
      endcase
   endfunction

   // Works out the direction word for one accepted request.
   function void note_request(logic [2:0] mode, logic [15:0] ra, logic [15:0] rb,
                              logic signed [15:0] cmax);
      longint one, u1, u2, x, y, z, s;
      logic on_circle;
      dir_word_type w;
      one = 64'd1 << 30;
      u1 = longint'(ra) << 14;
      u2 = longint'(rb) << 14;
      x = 0; y = 0; z = 0; s = 0;
      on_circle = 1'b1;
      case (mode)
         dsw_pkg::MODE_SPHERE: begin
            z = one - 2 * u1;
            s = root_q30(one - mul_q30(z, z));
         end
         dsw_pkg::MODE_HEMI: begin
            z = u1;
            s = root_q30(one - mul_q30(u1, u1));
         end
         dsw_pkg::MODE_COSINE: begin
            s = root_q30(u1);
            z = root_q30(one - u1);
         end
         dsw_pkg::MODE_CONE: begin
            z = one - u1 + mul_q30(u1, longint'(cmax) * 65536);
            s = root_q30(one - mul_q30(z, z));
         end
         dsw_pkg::MODE_TRI: begin
            s = root_q30(u1);
            x = one - s;
            y = mul_q30(s, u2);
            on_circle = 1'b0;
         end
         default: on_circle = 1'b0;
      endcase
      if (on_circle) rotate(s, {rb, 16'd0}, x, y);
      w.x = round_q14(x);
      w.y = round_q14(y);
      w.z = round_q14(z);
      pending_dirs.insert(pending_dirs.size(), w);
   endfunction

   function void check_result(logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z);
      dir_word_type w;
      if (pending_dirs.size() == 0) begin
         $error("response word with no request outstanding");
         error_count++;
         return;
      end
      w = pending_dirs.pop_front();
      checked_count++;
      if (x !== w.x) begin
         $error("dir_x expected %0d actual %0d", w.x, x); error_count++;
      end
      if (y !== w.y) begin
         $error("dir_y expected %0d actual %0d", w.y, y); error_count++;
      end
      if (z !== w.z) begin
         $error("dir_z expected %0d actual %0d", w.z, z); error_count++;
      end
   endfunction
endclass

FILE: verif/testbench.sv
// Top of the direction sample warp testbench: clock, reset, request driver, response
// stall generator and end-of-run check. Depends on direction_sample_warp_tb.sv and the RTL.
`timescale 1ns / 1ps

module testbench;
   // The pipeline is 54 stages deep; drain with some margin.
   localparam int LATENCY = 54;
   localparam int RANDOM_WORDS = 1030;
   localparam longint CYCLE_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_type = '0;
   logic [15:0] req_rand_a = '0;
   logic [15:0] req_rand_b = '0;
   logic signed [15:0] req_cone_cos_max = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_dir_x, rsp_dir_y, rsp_dir_z;

   direction_scoreboard dir_board = new();
   longint cycle_count = 0;
   int unsigned words_sent = 0;
   // Set while the receiver should hold off for a long stretch.
   logic long_hold = 1'b0;

   direction_sample_warp_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_rand_a(req_rand_a), .req_rand_b(req_rand_b),
      .req_cone_cos_max(req_cone_cos_max),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_dir_x(rsp_dir_x), .rsp_dir_y(rsp_dir_y), .rsp_dir_z(rsp_dir_z)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // The cycle counter doubles as a watchdog for a hung pipeline.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL direction_sample_warp_top");
         $finish;
      end
   end

   // Every accepted word is sampled at the clock edge, so the predictor and the
   // checker see exactly what the block saw, independent of event order.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         dir_board.note_request(req_type, req_rand_a, req_rand_b, req_cone_cos_max);
         words_sent++;
      end
      if (!reset && rsp_valid && !rsp_stall)
         dir_board.check_result(rsp_dir_x, rsp_dir_y, rsp_dir_z);
   end

   // The receiver draws a random stall length for each word, with stretches of no
   // stalling, and holds off for a long stretch whenever long_hold is raised.
   initial begin
      int gap;
      int calm;
      calm = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            // Long enough that the pipeline fills completely and backs up.
            repeat (3 * LATENCY) @(posedge clock);
            long_hold = 1'b0;
            rsp_stall <= 1'b0;
         end else if (rsp_valid && !rsp_stall) begin
            if (calm > 0) begin
               calm--;
            end else begin
               gap = $urandom_range(0, 3);
               if ($urandom_range(0, 15) == 0) calm = $urandom_range(20, 80);
               if (gap > 0) begin
                  rsp_stall <= 1'b1;
                  repeat (gap) @(posedge clock);
                  rsp_stall <= 1'b0;
               end
            end
         end
      end
   end

   // Offers one request word and waits until it is accepted. The payload holds
   // steady while the block stalls the request side.
   task automatic send_word(input logic [2:0] mode, input logic [15:0] ra,
                            input logic [15:0] rb, input logic signed [15:0] cmax,
                            input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= mode;
      req_rand_a <= ra;
      req_rand_b <= rb;
      req_cone_cos_max <= cmax;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Picks a random request; most are well formed, a few use unknown modes or
   // cone cosines outside plus or minus one.
   task automatic send_random(input int gap);
      logic [2:0] mode;
      logic [15:0] ra, rb;
      logic signed [15:0] cmax;
      mode = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 4));
      ra = 16'($urandom);
      rb = 16'($urandom);
      if ($urandom_range(0, 9) == 0) cmax = 16'($urandom);
      else cmax = 16'(int'($urandom_range(0, 32768)) - 16384);
      if ($urandom_range(0, 9) == 0) ra = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      send_word(mode, ra, rb, cmax, gap);
   endtask

   task automatic wait_drained();
      while (dir_board.pending_dirs.size() != 0) @(posedge clock);
   endtask

   initial begin
      int gap;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words: field extremes, every mode, unknown modes, a cone cosine
      // past plus one and past minus one, and each quadrant boundary of phi.
      send_word(dsw_pkg::MODE_SPHERE, 16'h0000, 16'h0000, 16'sd0, 0);
      send_word(dsw_pkg::MODE_SPHERE, 16'hFFFF, 16'hFFFF, 16'sd0, 0);
      send_word(dsw_pkg::MODE_SPHERE, 16'h8000, 16'h4000, 16'sd0, 0);
      send_word(dsw_pkg::MODE_HEMI, 16'h0000, 16'h8000, 16'sd0, 0);
      send_word(dsw_pkg::MODE_HEMI, 16'hFFFF, 16'hC000, 16'sd0, 0);
      send_word(dsw_pkg::MODE_COSINE, 16'h0000, 16'h0000, 16'sd0, 0);
      send_word(dsw_pkg::MODE_COSINE, 16'hFFFF, 16'h3FFF, 16'sd0, 0);
      send_word(dsw_pkg::MODE_CONE, 16'hFFFF, 16'h1234, 16'sd16384, 0);
      send_word(dsw_pkg::MODE_CONE, 16'hFFFF, 16'h7FFF, -16'sd16384, 0);
      send_word(dsw_pkg::MODE_CONE, 16'h8000, 16'hBFFF, 16'sd0, 0);
      send_word(dsw_pkg::MODE_CONE, 16'hFFFF, 16'h5555, 16'sh7FFF, 0);
      send_word(dsw_pkg::MODE_CONE, 16'hFFFF, 16'hAAAA, 16'sh8000, 0);
      send_word(dsw_pkg::MODE_CONE, 16'h0000, 16'hFFFF, 16'shFFFF, 0);
      send_word(dsw_pkg::MODE_TRI, 16'h0000, 16'h0000, 16'sd0, 0);
      send_word(dsw_pkg::MODE_TRI, 16'hFFFF, 16'hFFFF, 16'sd0, 0);
      send_word(dsw_pkg::MODE_TRI, 16'h4000, 16'h8000, 16'sd0, 0);
      send_word(3'd5, 16'hFFFF, 16'hFFFF, 16'sh7FFF, 0);
      send_word(3'd6, 16'h1234, 16'h5678, 16'sd0, 0);
      send_word(3'd7, 16'hAAAA, 16'h5555, 16'sh5555, 0);

      // The sender pauses here until every predicted direction has come back.
      req_valid <= 1'b0;
      wait_drained();

      // Random words; the receiver holds off once for a long stretch while the
      // sender keeps offering, so the pipeline fills and stalls its input.
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i == 300) long_hold = 1'b1;
         if (i == 700) begin
            req_valid <= 1'b0;
            wait_drained();
         end
         if ((i / 100) % 3 == 1) gap = 0;
         else gap = $urandom_range(0, 3);
         send_random(gap);
      end
      req_valid <= 1'b0;

      wait_drained();
      repeat (2 * LATENCY) @(posedge clock);
      $display("Covered %0d request words over all five modes, unknown modes and",
               words_sent);
      $display("out-of-range cone cosines; %0d direction words checked.",
               dir_board.checked_count);
      if (dir_board.error_count == 0 && dir_board.pending_dirs.size() == 0) begin
         $display("PASS direction_sample_warp_top");
      end else begin
         $display("FAIL direction_sample_warp_top");
      end
      $finish;
   end
endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/dsw_pkg.sv
hw/rtl/dsw_root_pair.sv
hw/rtl/dsw_rotator.sv
hw/rtl/direction_sample_warp_top.sv
verif/direction_sample_warp_tb.sv
verif/testbench.sv
